// File: hdl/grs_pkg.sv
// grs_pkg: shared types for the group reverse stream core.
// Payload structs, cell shift codes and sequencer states.
// No dependencies.
package grs_pkg;

  localparam int VALUE_W = 32;
  localparam int GSIZE_W = 5;
  localparam logic [GSIZE_W-1:0] GSIZE_RESET = GSIZE_W'(3);

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      seq_end;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value_out;
    logic                      last_out;
  } out_item_t;

  // Cell move: keep, take upper neighbor, take lower neighbor.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_DOWN,
    CELL_UP
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_REV,
    ST_SKIP,
    ST_FWD
  } grs_state_t;

endpackage

// File: hdl/grs_cell.sv
// grs_cell: one storage cell of the group buffer chain.
// Holds one value, loads from either neighbor. Uses grs_pkg.
module grs_cell (
  input  logic                           clk,
  input  grs_pkg::cell_op_t              op,
  input  logic signed [grs_pkg::VALUE_W-1:0] lo,
  input  logic signed [grs_pkg::VALUE_W-1:0] hi,
  output logic signed [grs_pkg::VALUE_W-1:0] q
);
  import grs_pkg::*;

  always_ff @(posedge clk) begin
    unique case (op)
      CELL_DOWN: q <= hi;
      CELL_UP:   q <= lo;
      default:   q <= q;
    endcase
  end

endmodule

// File: hdl/group_reverse_stream_core.sv
// group_reverse_stream_core: reverses a value stream in groups of group_size.
// The transfer that completes a group moves the sequencer to ST_REV; a group
// of n drains at one result per cycle while result_stall is low, input stalled.
// A partial group at seq_end shifts oldest to cell 0, then drains in arrival order.
// Throughput: one input transfer per cycle while a group fills.
// Reset (rst, sync): sequencer to load, fill count 0, group_size 3, no result.
module group_reverse_stream_core #(
  parameter int MAX_GROUP = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // input channel
  input  logic                            item_valid,
  output logic                            item_stall,
  input  grs_pkg::in_item_t               item,
  // result channel
  output logic                            result_valid,
  input  logic                            result_stall,
  output grs_pkg::out_item_t              result,
  // group_size register
  input  logic                            cfg_we,
  input  logic [grs_pkg::GSIZE_W-1:0]     cfg_data
);
  import grs_pkg::*;

  localparam int CW = $clog2(MAX_GROUP + 1);
  localparam int GW = (CW > GSIZE_W) ? CW : GSIZE_W;

  // Chain of cells. New values enter at the top (MAX_GROUP-1) while the chain
  // shifts down, so the newest item sits at the top and the oldest of n items
  // at MAX_GROUP-n. Reversed drain reads the top and shifts up; in-order drain
  // first shifts the oldest down to cell 0, then reads cell 0 and shifts down.
  logic signed [VALUE_W-1:0] cq [MAX_GROUP];
  cell_op_t                  op;

  for (genvar i = 0; i < MAX_GROUP; i++) begin : g_cell
    logic signed [VALUE_W-1:0] lo_n, hi_n;
    if (i == 0) begin : g_lo0
      assign lo_n = '0;
    end else begin : g_lo
      assign lo_n = cq[i-1];
    end
    if (i == MAX_GROUP - 1) begin : g_hitop
      assign hi_n = item.value;
    end else begin : g_hi
      assign hi_n = cq[i+1];
    end
    grs_cell u_cell (
      .clk (clk),
      .op  (op),
      .lo  (lo_n),
      .hi  (hi_n),
      .q   (cq[i])
    );
  end

  // Configuration register and its clamped effective value.
  logic [GSIZE_W-1:0] group_size;
  logic [GW-1:0]      gs_ext;
  logic [CW-1:0]      gsize_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= GSIZE_RESET;
    end else if (cfg_we) begin
      group_size <= cfg_data;
    end
  end

  always_comb begin
    gs_ext = GW'(group_size);
    priority if (gs_ext == '0) begin
      gsize_eff = CW'(1);
    end else if (gs_ext > GW'(MAX_GROUP)) begin
      gsize_eff = CW'(MAX_GROUP);
    end else begin
      gsize_eff = CW'(gs_ext);
    end
  end

  // Sequencer state
  grs_state_t state, state_next;
  logic [CW-1:0] fill, fill_next;
  logic [CW-1:0] rem, rem_next;     // results left in the current drain
  logic [CW-1:0] skip, skip_next;   // shifts left before in-order drain
  logic          end_flag, end_flag_next;
  logic          result_valid_next;
  out_item_t     result_next;

  logic          take;              // input transfer this cycle
  logic          out_free;          // output register can accept a result
  logic [CW-1:0] n_new;

  assign item_stall = (state != ST_LOAD);
  assign take       = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign n_new      = fill + CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      fill         <= '0;
      rem          <= '0;
      skip         <= '0;
      end_flag     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      fill         <= fill_next;
      rem          <= rem_next;
      skip         <= skip_next;
      end_flag     <= end_flag_next;
      result_valid <= result_valid_next;
    end
  end

  // Output payload needs no reset.
  always_ff @(posedge clk) begin
    result <= result_next;
  end

  always_comb begin
    state_next        = state;
    fill_next         = fill;
    rem_next          = rem;
    skip_next         = skip;
    end_flag_next     = end_flag;
    result_next       = result;
    result_valid_next = result_valid && result_stall;
    op                = CELL_HOLD;

    unique case (state)
      ST_LOAD: begin
        if (take) begin
          op = CELL_DOWN;
          priority if (n_new >= gsize_eff) begin
            // full group (or size lowered): drain reversed
            state_next    = ST_REV;
            rem_next      = n_new;
            end_flag_next = item.seq_end;
            fill_next     = '0;
          end else if (item.seq_end) begin
            // partial tail: drain in arrival order
            rem_next      = n_new;
            end_flag_next = 1'b1;
            fill_next     = '0;
            skip_next     = CW'(MAX_GROUP) - n_new;
            state_next    = (CW'(MAX_GROUP) == n_new) ? ST_FWD : ST_SKIP;
          end else begin
            fill_next = n_new;
          end
        end
      end
      ST_SKIP: begin
        op        = CELL_DOWN;
        skip_next = skip - CW'(1);
        if (skip == CW'(1)) begin
          state_next = ST_FWD;
        end
      end
      ST_REV, ST_FWD: begin
        if (out_free) begin
          if (state == ST_REV) begin
            op                    = CELL_UP;
            result_next.value_out = cq[MAX_GROUP-1];
          end else begin
            op                    = CELL_DOWN;
            result_next.value_out = cq[0];
          end
          result_next.last_out = end_flag && (rem == CW'(1));
          result_valid_next    = 1'b1;
          rem_next             = rem - CW'(1);
          if (rem == CW'(1)) begin
            state_next = ST_LOAD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule
